[rtl/core/nrs_pkg.sv]
package nrs_pkg;

    localparam int MAX_AXES_DEF = 32;

    // 2^62, the ceiling on a partial size product
    localparam logic [62:0] SIZE_LIMIT = 63'h4000_0000_0000_0000;

    localparam logic [1:0] CMD_LOAD_OLD = 2'd0;
    localparam logic [1:0] CMD_LOAD_NEW = 2'd1;
    localparam logic [1:0] CMD_COMPUTE  = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_COPY     = 2'd1;
    localparam logic [1:0] STAT_MISMATCH = 2'd2;
    localparam logic [1:0] STAT_OVERFLOW = 2'd3;

    localparam logic CFG_FORTRAN = 1'b0;
    localparam logic CFG_ITEM    = 1'b1;

    localparam logic [15:0] ITEM_BYTES_RST = 16'd8;

    typedef enum logic [4:0] {
        ST_IDLE, ST_START, ST_ERR_OVF, ST_ERR_SIZE, ST_GRP, ST_CMP, ST_MLO, ST_MHI,
        ST_MCHK, ST_CONT, ST_CONTCHK, ST_SPINIT, ST_SP, ST_SPW, ST_END, ST_TAIL1,
        ST_TAIL2, ST_EMIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_START, OP_ERR_OVF, OP_ERR_SIZE, OP_GRP, OP_CMP, OP_MLO, OP_MHI,
        OP_MCHK, OP_CONT, OP_CONTCHK, OP_SPINIT, OP_SP, OP_SPW, OP_END, OP_TAIL1,
        OP_TAIL2, OP_EMIT
    } t_op;

    typedef struct packed {
        logic in_ready;
        t_op  op;
    } t_ctl_cmd;

    typedef struct packed {
        logic go;
        logic ovf;
        logic zero;
        logic grp_go;
        logic eq;
        logic lt;
        logic nj_end;
        logic oj_end;
        logic grow_fail;
        logic tgt_new;
        logic sp_more;
        logic tail_needed;
        logic emit_done;
    } t_dp_stat;

endpackage

[rtl/core/nrs_ctrl.sv]
module nrs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nrs_pkg::t_dp_stat   i_stat,
    output nrs_pkg::t_ctl_cmd   o_cmd
);

    nrs_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nrs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            nrs_pkg::ST_IDLE: begin
                if (i_stat.go) n_state = nrs_pkg::ST_START;
            end
            nrs_pkg::ST_START: begin
                if (i_stat.ovf)       n_state = nrs_pkg::ST_ERR_OVF;
                else if (i_stat.zero) n_state = nrs_pkg::ST_ERR_SIZE;
                else                  n_state = nrs_pkg::ST_GRP;
            end
            nrs_pkg::ST_ERR_OVF:  n_state = nrs_pkg::ST_EMIT;
            nrs_pkg::ST_ERR_SIZE: n_state = nrs_pkg::ST_EMIT;
            nrs_pkg::ST_GRP: begin
                n_state = i_stat.grp_go ? nrs_pkg::ST_CMP : nrs_pkg::ST_END;
            end
            nrs_pkg::ST_CMP: begin
                if (i_stat.eq)                          n_state = nrs_pkg::ST_SPINIT;
                else if (i_stat.lt && i_stat.nj_end)    n_state = nrs_pkg::ST_ERR_SIZE;
                else if (!i_stat.lt && i_stat.oj_end)   n_state = nrs_pkg::ST_ERR_SIZE;
                else                                    n_state = nrs_pkg::ST_MLO;
            end
            nrs_pkg::ST_MLO: n_state = nrs_pkg::ST_MHI;
            nrs_pkg::ST_MHI: n_state = nrs_pkg::ST_MCHK;
            nrs_pkg::ST_MCHK: begin
                if (i_stat.grow_fail)    n_state = nrs_pkg::ST_ERR_SIZE;
                else if (i_stat.tgt_new) n_state = nrs_pkg::ST_CMP;
                else                     n_state = nrs_pkg::ST_CONT;
            end
            nrs_pkg::ST_CONT:    n_state = nrs_pkg::ST_CONTCHK;
            nrs_pkg::ST_CONTCHK: n_state = nrs_pkg::ST_CMP;
            nrs_pkg::ST_SPINIT:  n_state = nrs_pkg::ST_SP;
            nrs_pkg::ST_SP: begin
                n_state = i_stat.sp_more ? nrs_pkg::ST_SPW : nrs_pkg::ST_GRP;
            end
            nrs_pkg::ST_SPW: n_state = nrs_pkg::ST_SP;
            nrs_pkg::ST_END: begin
                n_state = i_stat.tail_needed ? nrs_pkg::ST_TAIL1 : nrs_pkg::ST_EMIT;
            end
            nrs_pkg::ST_TAIL1: n_state = nrs_pkg::ST_TAIL2;
            nrs_pkg::ST_TAIL2: n_state = nrs_pkg::ST_EMIT;
            nrs_pkg::ST_EMIT: begin
                if (i_stat.emit_done) n_state = nrs_pkg::ST_IDLE;
            end
            default: n_state = nrs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.in_ready = 1'b0;
        o_cmd.op       = nrs_pkg::OP_NONE;
        case (r_state)
            nrs_pkg::ST_IDLE:     o_cmd.in_ready = 1'b1;
            nrs_pkg::ST_START:    o_cmd.op = nrs_pkg::OP_START;
            nrs_pkg::ST_ERR_OVF:  o_cmd.op = nrs_pkg::OP_ERR_OVF;
            nrs_pkg::ST_ERR_SIZE: o_cmd.op = nrs_pkg::OP_ERR_SIZE;
            nrs_pkg::ST_GRP:      o_cmd.op = nrs_pkg::OP_GRP;
            nrs_pkg::ST_CMP:      o_cmd.op = nrs_pkg::OP_CMP;
            nrs_pkg::ST_MLO:      o_cmd.op = nrs_pkg::OP_MLO;
            nrs_pkg::ST_MHI:      o_cmd.op = nrs_pkg::OP_MHI;
            nrs_pkg::ST_MCHK:     o_cmd.op = nrs_pkg::OP_MCHK;
            nrs_pkg::ST_CONT:     o_cmd.op = nrs_pkg::OP_CONT;
            nrs_pkg::ST_CONTCHK:  o_cmd.op = nrs_pkg::OP_CONTCHK;
            nrs_pkg::ST_SPINIT:   o_cmd.op = nrs_pkg::OP_SPINIT;
            nrs_pkg::ST_SP:       o_cmd.op = nrs_pkg::OP_SP;
            nrs_pkg::ST_SPW:      o_cmd.op = nrs_pkg::OP_SPW;
            nrs_pkg::ST_END:      o_cmd.op = nrs_pkg::OP_END;
            nrs_pkg::ST_TAIL1:    o_cmd.op = nrs_pkg::OP_TAIL1;
            nrs_pkg::ST_TAIL2:    o_cmd.op = nrs_pkg::OP_TAIL2;
            nrs_pkg::ST_EMIT:     o_cmd.op = nrs_pkg::OP_EMIT;
            default:              o_cmd.op = nrs_pkg::OP_NONE;
        endcase
    end

endmodule

[rtl/core/nrs_dp.sv]
module nrs_dp #(
    parameter int MAX_AXES = nrs_pkg::MAX_AXES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nrs_pkg::t_ctl_cmd   i_cmd,
    output nrs_pkg::t_dp_stat   o_stat,
    input  logic                i_in_valid,
    input  logic [1:0]          i_command,
    input  logic [30:0]         i_axis_size,
    input  logic [31:0]         i_axis_stride,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [1:0]          o_status,
    output logic [4:0]          o_axis_index,
    output logic [31:0]         o_new_stride,
    output logic                o_stride_valid,
    output logic                o_last,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [15:0]         i_cfg_wdata
);

    localparam int AW = $clog2(MAX_AXES);
    localparam int CW = $clog2(MAX_AXES + 2);

    logic [30:0] r_osz  [MAX_AXES];
    logic [31:0] r_ostr [MAX_AXES];
    logic [30:0] r_nsz  [MAX_AXES];
    logic [31:0] r_ns   [MAX_AXES];

    logic [CW-1:0] r_ocnt, r_ncnt, r_nz;
    logic          r_ovf, r_zero, r_fortran;
    logic [15:0]   r_item;
    logic [CW-1:0] r_oi, r_oj, r_ni, r_nj, r_k, r_ek;
    logic [62:0]   r_np, r_op, r_plo;
    logic [30:0]   r_fac, r_last_sz;
    logic          r_tgt_new, r_copy;
    logic [31:0]   r_first, r_last_str, r_cur, r_tail;
    logic [63:0]   r_mul;
    logic [1:0]    r_status;
    logic          r_out_valid;
    logic [1:0]    r_out_status;
    logic [4:0]    r_out_index;
    logic [31:0]   r_out_stride;
    logic          r_out_sv, r_out_last;

    logic          w_accept, w_load_old, w_load_new;
    logic [CW-1:0] w_nim1, w_njm1, w_kp1, w_km1;
    logic [AW-1:0] w_oaddr, w_naddr, w_saddr;
    logic [30:0]   w_osz, w_nsz;
    logic [31:0]   w_ostr, w_ns;
    logic [62:0]   w_acc;
    logic [31:0]   w_ma, w_mb;
    logic [63:0]   w_prod;
    logic [93:0]   w_sum;
    logic          w_fail, w_sp_more, w_single, w_last, w_out_free, w_emit;
    logic [1:0]    w_end_code;

    assign w_accept   = i_in_valid && i_cmd.in_ready;
    assign w_load_old = w_accept && (i_command == nrs_pkg::CMD_LOAD_OLD)
                        && (i_axis_size != 31'd1);
    assign w_load_new = w_accept && (i_command == nrs_pkg::CMD_LOAD_NEW);

    assign w_nim1  = CW'(r_ni - CW'(1));
    assign w_njm1  = CW'(r_nj - CW'(1));
    assign w_kp1   = CW'(r_k + CW'(1));
    assign w_km1   = CW'(r_k - CW'(1));
    assign w_oaddr = (i_cmd.op == nrs_pkg::OP_GRP) ? r_oi[AW-1:0] : r_oj[AW-1:0];

    always_comb begin
        case (i_cmd.op)
            nrs_pkg::OP_GRP:   w_naddr = r_ni[AW-1:0];
            nrs_pkg::OP_SP:    w_naddr = r_k[AW-1:0];
            nrs_pkg::OP_TAIL1: w_naddr = w_nim1[AW-1:0];
            default:           w_naddr = r_nj[AW-1:0];
        endcase
    end

    assign w_saddr = (i_cmd.op == nrs_pkg::OP_TAIL1) ? w_nim1[AW-1:0] : r_ek[AW-1:0];

    assign w_osz  = r_osz[w_oaddr];
    assign w_ostr = r_ostr[w_oaddr];
    assign w_nsz  = r_nsz[w_naddr];
    assign w_ns   = r_ns[w_saddr];

    // one shared 32x32 multiplier, product always registered
    assign w_acc = r_tgt_new ? r_np : r_op;

    always_comb begin
        case (i_cmd.op)
            nrs_pkg::OP_MLO: begin
                w_ma = w_acc[31:0];
                w_mb = {1'b0, r_fac};
            end
            nrs_pkg::OP_MHI: begin
                w_ma = {1'b0, w_acc[62:32]};
                w_mb = {1'b0, r_fac};
            end
            nrs_pkg::OP_CONT: begin
                w_ma = r_fortran ? r_last_str : w_ostr;
                w_mb = r_fortran ? {1'b0, r_last_sz} : {1'b0, w_osz};
            end
            nrs_pkg::OP_TAIL1: begin
                w_ma = w_ns;
                w_mb = r_fortran ? {1'b0, w_nsz} : 32'd1;
            end
            default: begin
                w_ma = r_cur;
                w_mb = {1'b0, w_nsz};
            end
        endcase
    end

    assign w_prod = {32'd0, w_ma} * {32'd0, w_mb};
    assign w_sum  = {r_mul[61:0], 32'd0} + 94'(r_plo);
    assign w_fail = w_sum > 94'(nrs_pkg::SIZE_LIMIT);

    assign w_sp_more = r_fortran ? (w_kp1 < r_nj) : (r_k > r_ni);

    always_comb begin
        if ((r_oi < r_ocnt) || (r_nz > r_ni)) w_end_code = nrs_pkg::STAT_MISMATCH;
        else if (r_copy)                      w_end_code = nrs_pkg::STAT_COPY;
        else                                  w_end_code = nrs_pkg::STAT_OK;
    end

    assign w_single   = (r_status != nrs_pkg::STAT_OK) || (r_ncnt == '0);
    assign w_last     = w_single || (CW'(r_ek + CW'(1)) == r_ncnt);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_emit     = (i_cmd.op == nrs_pkg::OP_EMIT) && w_out_free;

    assign o_stat.go          = w_accept && (i_command == nrs_pkg::CMD_COMPUTE);
    assign o_stat.ovf         = r_ovf;
    assign o_stat.zero        = r_zero;
    assign o_stat.grp_go      = (r_ni < r_ncnt) && (r_oi < r_ocnt);
    assign o_stat.eq          = r_np == r_op;
    assign o_stat.lt          = r_np < r_op;
    assign o_stat.nj_end      = r_nj >= r_ncnt;
    assign o_stat.oj_end      = r_oj >= r_ocnt;
    assign o_stat.grow_fail   = w_fail;
    assign o_stat.tgt_new     = r_tgt_new;
    assign o_stat.sp_more     = w_sp_more;
    assign o_stat.tail_needed = (w_end_code == nrs_pkg::STAT_OK) && (r_ni != '0);
    assign o_stat.emit_done   = w_emit && w_last;

    // control state: counts, flags, configuration, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocnt      <= '0;
            r_ncnt      <= '0;
            r_nz        <= '0;
            r_ovf       <= 1'b0;
            r_zero      <= 1'b0;
            r_fortran   <= 1'b0;
            r_item      <= nrs_pkg::ITEM_BYTES_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == nrs_pkg::CFG_FORTRAN) r_fortran <= i_cfg_wdata[0];
                else                                     r_item    <= i_cfg_wdata;
            end
            if (w_load_old) begin
                if (r_ocnt >= CW'(MAX_AXES)) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_ocnt <= CW'(r_ocnt + CW'(1));
                    if (i_axis_size == 31'd0) r_zero <= 1'b1;
                end
            end
            if (w_load_new) begin
                if (r_ncnt >= CW'(MAX_AXES)) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_ncnt <= CW'(r_ncnt + CW'(1));
                    if (i_axis_size == 31'd0) r_zero <= 1'b1;
                    if (i_axis_size != 31'd1) r_nz <= CW'(r_ncnt + CW'(1));
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
                if (w_last) begin
                    r_ocnt <= '0;
                    r_ncnt <= '0;
                    r_nz   <= '0;
                    r_ovf  <= 1'b0;
                    r_zero <= 1'b0;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // stores and working registers
    always_ff @(posedge i_clk) begin
        if (w_load_old && (r_ocnt < CW'(MAX_AXES))) begin
            r_osz[r_ocnt[AW-1:0]]  <= i_axis_size;
            r_ostr[r_ocnt[AW-1:0]] <= i_axis_stride;
        end
        if (w_load_new && (r_ncnt < CW'(MAX_AXES))) begin
            r_nsz[r_ncnt[AW-1:0]] <= i_axis_size;
        end
        case (i_cmd.op)
            nrs_pkg::OP_START: begin
                r_oi   <= '0;
                r_oj   <= CW'(1);
                r_ni   <= '0;
                r_nj   <= CW'(1);
                r_ek   <= '0;
                r_copy <= 1'b0;
            end
            nrs_pkg::OP_ERR_OVF:  r_status <= nrs_pkg::STAT_OVERFLOW;
            nrs_pkg::OP_ERR_SIZE: r_status <= nrs_pkg::STAT_MISMATCH;
            nrs_pkg::OP_GRP: begin
                r_np       <= 63'(w_nsz);
                r_op       <= 63'(w_osz);
                r_first    <= w_ostr;
                r_last_str <= w_ostr;
                r_last_sz  <= w_osz;
            end
            nrs_pkg::OP_CMP: begin
                r_tgt_new <= r_np < r_op;
                r_fac     <= (r_np < r_op) ? w_nsz : w_osz;
            end
            nrs_pkg::OP_MLO: r_mul <= w_prod;
            nrs_pkg::OP_MHI: begin
                r_plo <= r_mul[62:0];
                r_mul <= w_prod;
            end
            nrs_pkg::OP_MCHK: begin
                if (!w_fail) begin
                    if (r_tgt_new) begin
                        r_np <= w_sum[62:0];
                        r_nj <= CW'(r_nj + CW'(1));
                    end else begin
                        r_op <= w_sum[62:0];
                    end
                end
            end
            nrs_pkg::OP_CONT: r_mul <= w_prod;
            nrs_pkg::OP_CONTCHK: begin
                if (r_mul[31:0] != (r_fortran ? w_ostr : r_last_str)) r_copy <= 1'b1;
                r_last_sz  <= w_osz;
                r_last_str <= w_ostr;
                r_oj       <= CW'(r_oj + CW'(1));
            end
            nrs_pkg::OP_SPINIT: begin
                if (r_fortran) begin
                    r_k               <= r_ni;
                    r_ns[r_ni[AW-1:0]] <= r_first;
                    r_cur             <= r_first;
                end else begin
                    r_k   <= w_njm1;
                    r_ns[w_njm1[AW-1:0]] <= r_last_str;
                    r_cur <= r_last_str;
                end
            end
            nrs_pkg::OP_SP: begin
                if (w_sp_more) begin
                    r_mul <= w_prod;
                end else begin
                    r_ni <= r_nj;
                    r_nj <= CW'(r_nj + CW'(1));
                    r_oi <= r_oj;
                    r_oj <= CW'(r_oj + CW'(1));
                end
            end
            nrs_pkg::OP_SPW: begin
                r_cur <= r_mul[31:0];
                if (r_fortran) begin
                    r_k <= w_kp1;
                    r_ns[w_kp1[AW-1:0]] <= r_mul[31:0];
                end else begin
                    r_k <= w_km1;
                    r_ns[w_km1[AW-1:0]] <= r_mul[31:0];
                end
            end
            nrs_pkg::OP_END: begin
                r_status <= w_end_code;
                r_tail   <= 32'(r_item);
            end
            nrs_pkg::OP_TAIL1: r_mul  <= w_prod;
            nrs_pkg::OP_TAIL2: r_tail <= r_mul[31:0];
            nrs_pkg::OP_EMIT: begin
                if (w_out_free) begin
                    r_out_status <= r_status;
                    r_out_index  <= w_single ? 5'd0 : 5'(r_ek);
                    r_out_stride <= w_single ? 32'd0 : ((r_ek < r_ni) ? w_ns : r_tail);
                    r_out_sv     <= !w_single;
                    r_out_last   <= w_last;
                    r_ek         <= CW'(r_ek + CW'(1));
                end
            end
            default: r_copy <= r_copy;
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_axis_index   = r_out_index;
    assign o_new_stride   = r_out_stride;
    assign o_stride_valid = r_out_sv;
    assign o_last         = r_out_last;

endmodule

[rtl/core/nocopy_reshape_strides.sv]
// Loads can follow back to back. Compute: a setup step, then per group a load, a compare,
// a 63-bit multiply-and-check per grown axis, a contiguity check per grown old axis and a
// stride spread; then a last group check, an end step and, if needed, the tail; errors skip
// to the end. Results (1..MAX_AXES) then leave one per cycle unless the receiver stalls;
// input stalls until the last is registered. The shared 32x32 multiplier sets the pace.
// Reset (sync, active low) empties shapes, clears flags, fortran_order 0, item_bytes 8.
module nocopy_reshape_strides #(
    parameter int MAX_AXES = nrs_pkg::MAX_AXES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item input
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_command,
    input  logic [30:0]        i_axis_size,
    input  logic signed [31:0] i_axis_stride,
    // result output
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic [4:0]         o_axis_index,
    output logic signed [31:0] o_new_stride,
    output logic               o_stride_valid,
    output logic               o_last,
    // configuration writes: index 0 fortran_order, 1 item_bytes
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_wdata
);

    nrs_pkg::t_ctl_cmd w_cmd;
    nrs_pkg::t_dp_stat w_stat;
    logic [31:0]       w_stride;

    // input is taken only while the sequencer idles; a waiting result
    // in the output register does not hold off loads
    assign o_in_stall = !w_cmd.in_ready;

    nrs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    nrs_dp #(
        .MAX_AXES (MAX_AXES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_in_valid     (i_in_valid),
        .i_command      (i_command),
        .i_axis_size    (i_axis_size),
        .i_axis_stride  (i_axis_stride),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_axis_index   (o_axis_index),
        .o_new_stride   (w_stride),
        .o_stride_valid (o_stride_valid),
        .o_last         (o_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    assign o_new_stride = w_stride;

endmodule

[rtl/core/nrs_checker.sv]
module nrs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_command,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [4:0]  o_axis_index,
    input logic [31:0] o_new_stride,
    input logic        o_stride_valid,
    input logic        o_last
);

    a_compute_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_command == nrs_pkg::CMD_COMPUTE) |=> o_in_stall)
        else $error("input not stalled after compute");

    a_no_stride_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_stride_valid) |-> (o_last && o_axis_index == 5'd0
                                               && o_new_stride == 32'd0))
        else $error("strideless result not a lone final item");

    a_err_no_stride: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != nrs_pkg::STAT_OK) |-> !o_stride_valid)
        else $error("stride with error status");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_new_stride)
                                          && $stable(o_axis_index)))
        else $error("stalled result changed");

endmodule

bind nocopy_reshape_strides nrs_checker u_nrs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_command      (i_command),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_axis_index   (o_axis_index),
    .o_new_stride   (o_new_stride),
    .o_stride_valid (o_stride_valid),
    .o_last         (o_last)
);

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import nrs_pkg::*;

    localparam int AXES        = MAX_AXES_DEF;
    localparam int WDOG_LIMIT  = 5000;  // idle cycles before we call it hung
    localparam int HOLD_LEN    = 400;   // long receiver hold-off
    localparam int ITEMS_TOTAL = 300;   // random traffic tops the run up to this

    typedef struct {
        logic [1:0]  status;
        logic [4:0]  axis_index;
        logic [31:0] new_stride;
        logic        stride_valid;
        logic        last;
    } t_stride_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_command;
    logic [30:0]        i_axis_size;
    logic signed [31:0] i_axis_stride;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [1:0]         o_status;
    logic [4:0]         o_axis_index;
    logic signed [31:0] o_new_stride;
    logic               o_stride_valid;
    logic               o_last;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [15:0]        i_cfg_wdata;

    nocopy_reshape_strides dut (.*);

    // shadow of the block: shapes, flags and registers
    logic [30:0] shd_old_size  [AXES];
    logic [31:0] shd_old_stride[AXES];
    logic [30:0] shd_new_size  [AXES];
    logic [31:0] shd_strides   [AXES];
    int          shd_old_n;
    int          shd_new_n;
    bit          shd_ovf;
    bit          shd_fortran;
    logic [15:0] shd_item_bytes;

    t_stride_result pending_strides[$];

    int  err_count;
    int  items_sent;
    bit  idle_on;      // sender and receiver draw random gaps when set
    int  hold_req;     // receiver hold-off request, picked up by the stall process
    int  stall_left;
    int  hold_left;
    int  wdog;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Grouping and stride prediction. Returns the status; on STAT_OK the
    // per-axis strides sit in shd_strides.
    function automatic logic [1:0] predict_strides();
        int              oi, oj, ni, nj, k;
        longint unsigned np, op;
        bit              copy;
        logic [31:0]     tail;
        oi = 0; oj = 1; ni = 0; nj = 1; copy = 0;
        if (shd_ovf) return STAT_OVERFLOW;
        for (k = 0; k < shd_old_n; k++) if (shd_old_size[k] == 0) return STAT_MISMATCH;
        for (k = 0; k < shd_new_n; k++) if (shd_new_size[k] == 0) return STAT_MISMATCH;
        while (ni < shd_new_n && oi < shd_old_n) begin
            np = shd_new_size[ni];
            op = shd_old_size[oi];
            // grow the smaller side until the size products meet
            while (np != op) begin
                if (np < op) begin
                    if (nj >= shd_new_n) return STAT_MISMATCH;
                    if (np > 64'(SIZE_LIMIT) / 64'(shd_new_size[nj])) return STAT_MISMATCH;
                    np = np * 64'(shd_new_size[nj]);
                    nj++;
                end else begin
                    if (oj >= shd_old_n) return STAT_MISMATCH;
                    if (op > 64'(SIZE_LIMIT) / 64'(shd_old_size[oj])) return STAT_MISMATCH;
                    op = op * 64'(shd_old_size[oj]);
                    oj++;
                end
            end
            // old axes of the group must be contiguous in the chosen order
            for (k = oi; k + 1 < oj; k++) begin
                if (shd_fortran) begin
                    if (shd_old_stride[k+1] != 32'(shd_old_size[k]) * shd_old_stride[k])
                        copy = 1;
                end else begin
                    if (shd_old_stride[k] != 32'(shd_old_size[k+1]) * shd_old_stride[k+1])
                        copy = 1;
                end
            end
            if (shd_fortran) begin
                shd_strides[ni] = shd_old_stride[oi];
                for (k = ni + 1; k < nj; k++)
                    shd_strides[k] = shd_strides[k-1] * 32'(shd_new_size[k-1]);
            end else begin
                shd_strides[nj-1] = shd_old_stride[oj-1];
                for (k = nj - 1; k > ni; k--)
                    shd_strides[k-1] = shd_strides[k] * 32'(shd_new_size[k]);
            end
            ni = nj; nj++;
            oi = oj; oj++;
        end
        if (oi < shd_old_n) return STAT_MISMATCH;
        for (k = ni; k < shd_new_n; k++) if (shd_new_size[k] != 1) return STAT_MISMATCH;
        if (copy) return STAT_COPY;
        // trailing size-1 axes; with nothing grouped the tail is just the item size
        if (ni >= 1) begin
            tail = shd_strides[ni-1];
            if (shd_fortran) tail = tail * 32'(shd_new_size[ni-1]);
        end else begin
            tail = 32'(shd_item_bytes);
        end
        for (k = ni; k < shd_new_n; k++) shd_strides[k] = tail;
        return STAT_OK;
    endfunction

    // update the shadow for one accepted item, queue what it should produce
    task automatic track_item(input logic [1:0] cmd, input logic [30:0] size,
                              input logic [31:0] stride);
        logic [1:0]     st;
        t_stride_result r;
        case (cmd)
            CMD_LOAD_OLD: begin
                if (size != 1) begin
                    if (shd_old_n >= AXES) begin
                        shd_ovf = 1;
                    end else begin
                        shd_old_size[shd_old_n]   = size;
                        shd_old_stride[shd_old_n] = stride;
                        shd_old_n++;
                    end
                end
            end
            CMD_LOAD_NEW: begin
                if (shd_new_n >= AXES) begin
                    shd_ovf = 1;
                end else begin
                    shd_new_size[shd_new_n] = size;
                    shd_new_n++;
                end
            end
            CMD_COMPUTE: begin
                st = predict_strides();
                if (st != STAT_OK || shd_new_n == 0) begin
                    r = '{st, 5'd0, 32'd0, 1'b0, 1'b1};
                    pending_strides.push_back(r);
                end else begin
                    for (int k = 0; k < shd_new_n; k++) begin
                        r = '{STAT_OK, 5'(k), shd_strides[k], 1'b1, 1'(k + 1 == shd_new_n)};
                        pending_strides.push_back(r);
                    end
                end
                shd_old_n = 0;
                shd_new_n = 0;
                shd_ovf   = 0;
            end
            default: ;  // unused command, ignored
        endcase
    endtask

    // offer one item after a random gap, wait for acceptance; ends on a clock edge
    task automatic send_item(input logic [1:0] cmd, input logic [30:0] size,
                             input logic [31:0] stride);
        int gap;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_axis_size   <= size;
        i_axis_stride <= stride;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        track_item(cmd, size, stride);
    endtask

    // wait for the block to drain, then leave margin for a load still in flight
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_strides.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_FORTRAN) shd_fortran = value[0];
        else                    shd_item_bytes = value;
        @(posedge i_clk);
    endtask

    // One reshape: a random factor list is cut two ways into old and new axes,
    // so products match. Old strides are laid out contiguously in the current
    // order; when not clean, one stride or size gets broken.
    task automatic send_reshape(input bit clean, input int max_factors);
        int              nf, n_old, n_new, k, pick;
        longint unsigned f[AXES];
        longint unsigned osz[AXES];
        longint unsigned nsz[AXES];
        logic [31:0]     ost[AXES];
        logic [31:0]     base;
        nf    = $urandom_range(0, max_factors);
        n_old = 0;
        n_new = 0;
        for (k = 0; k < nf; k++) begin
            f[k] = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 50000) : $urandom_range(2, 6);
            if (k == 0 || $urandom_range(0, 1)) begin
                osz[n_old] = f[k];
                n_old++;
            end else begin
                osz[n_old-1] = osz[n_old-1] * f[k];
            end
            if (k == 0 || $urandom_range(0, 1)) begin
                nsz[n_new] = f[k];
                n_new++;
            end else begin
                nsz[n_new-1] = nsz[n_new-1] * f[k];
            end
        end
        base = ($urandom_range(0, 3) == 0) ? $urandom : 32'(shd_item_bytes);
        if (n_old > 0) begin
            if (shd_fortran) begin
                ost[0] = base;
                for (k = 1; k < n_old; k++) ost[k] = ost[k-1] * 32'(osz[k-1]);
            end else begin
                ost[n_old-1] = base;
                for (k = n_old - 2; k >= 0; k--) ost[k] = ost[k+1] * 32'(osz[k+1]);
            end
        end
        if (!clean && n_old > 0) begin
            pick = $urandom_range(0, n_old - 1);
            case ($urandom_range(0, 2))
                0:       ost[pick] = ost[pick] ^ 32'($urandom_range(1, 255));
                1:       osz[pick] = osz[pick] + 1;
                default: nsz[$urandom_range(0, n_new - 1)] = 0;
            endcase
        end
        for (k = 0; k < n_old; k++) begin
            if ($urandom_range(0, 4) == 0) send_item(CMD_LOAD_OLD, 31'd1, $urandom);
            send_item(CMD_LOAD_OLD, osz[k][30:0], ost[k]);
        end
        for (k = 0; k < n_new; k++) begin
            send_item(CMD_LOAD_NEW, nsz[k][30:0], $urandom);
            if ($urandom_range(0, 5) == 0) send_item(CMD_LOAD_NEW, 31'd1, $urandom);
        end
        if ($urandom_range(0, 9) == 0) send_item(2'd3, 31'($urandom), $urandom);
        send_item(CMD_COMPUTE, 31'($urandom), $urandom);
    endtask

    // garbage loads and commands, then a compute
    task automatic send_noise();
        int n;
        n = $urandom_range(0, 4);
        repeat (n) send_item(2'($urandom_range(0, 3)), 31'($urandom), $urandom);
        send_item(CMD_COMPUTE, 31'($urandom), $urandom);
    endtask

    task automatic test_directed();
        idle_on = 1;
        // empty shapes
        send_item(CMD_COMPUTE, 31'd0, 32'd0);
        // 2x3 C-contiguous -> 6, with a dropped size-1 old axis
        send_item(CMD_LOAD_OLD, 31'd2, 32'd24);
        send_item(CMD_LOAD_OLD, 31'd1, 32'hFFFF_FFFF);
        send_item(CMD_LOAD_OLD, 31'd3, 32'd8);
        send_item(CMD_LOAD_NEW, 31'd6, 32'h8000_0000);
        send_item(CMD_LOAD_NEW, 31'd1, 32'd0);
        send_item(CMD_COMPUTE, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        // non-contiguous pair -> copy needed
        send_item(CMD_LOAD_OLD, 31'd2, 32'd8);
        send_item(CMD_LOAD_OLD, 31'd3, 32'd8);
        send_item(CMD_LOAD_NEW, 31'd6, 32'd0);
        send_item(CMD_COMPUTE, 31'd0, 32'd0);
        // extreme sizes and strides; unused command in between
        send_item(CMD_LOAD_OLD, 31'h7FFF_FFFF, 32'h8000_0000);
        send_item(2'd3, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_LOAD_NEW, 31'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(CMD_COMPUTE, 31'd0, 32'd0);
        // zero size
        send_item(CMD_LOAD_NEW, 31'd0, 32'd0);
        send_item(CMD_COMPUTE, 31'd0, 32'd0);
        // product mismatch
        send_item(CMD_LOAD_OLD, 31'd4, 32'd8);
        send_item(CMD_LOAD_NEW, 31'd5, 32'd0);
        send_item(CMD_COMPUTE, 31'd0, 32'd0);
        // only size-1 new axes: stride is the item size
        send_item(CMD_LOAD_NEW, 31'd1, 32'd0);
        send_item(CMD_LOAD_NEW, 31'd1, 32'd0);
        send_item(CMD_COMPUTE, 31'd0, 32'd0);
        wait_idle();
    endtask

    task automatic test_overflow();
        idle_on = 0;
        // one more old axis than fits
        repeat (AXES + 1) send_item(CMD_LOAD_OLD, 31'd2, $urandom);
        send_item(CMD_COMPUTE, 31'd0, 32'd0);
        repeat (AXES + 1) send_item(CMD_LOAD_NEW, 31'd1, 32'd0);
        send_item(CMD_COMPUTE, 31'd0, 32'd0);
        // exactly full: 32 new axes in 16 groups, random strides mostly force a copy
        repeat (AXES) send_item(CMD_LOAD_NEW, 31'd2, 32'd0);
        repeat (AXES / 2) send_item(CMD_LOAD_OLD, 31'd4, $urandom);
        send_item(CMD_COMPUTE, 31'd0, 32'd0);
        // size product past 2^62: both sides grow until the new side overshoots
        repeat (3) send_item(CMD_LOAD_OLD, 31'h7FFF_FFFF, 32'd8);
        send_item(CMD_LOAD_NEW, 31'h7FFF_FFFE, 32'd0);
        send_item(CMD_LOAD_NEW, 31'h7FFF_FFFF, 32'd0);
        send_item(CMD_LOAD_NEW, 31'h7FFF_FFFF, 32'd0);
        send_item(CMD_COMPUTE, 31'd0, 32'd0);
        wait_idle();
    endtask

    // walk the registers through their extremes, then random item sizes, a reshape per setting
    task automatic test_config();
        logic [15:0] item_vals[4];
        item_vals = '{16'd1, 16'hFFFF, 16'h8000, 16'd8};
        for (int s = 0; s < 8; s++) begin
            write_cfg(CFG_FORTRAN, 16'(s % 2));
            write_cfg(CFG_ITEM, (s < 4) ? item_vals[s / 2 * 2 + s % 2] : 16'($urandom));
            idle_on = 1;
            send_item(CMD_LOAD_NEW, 31'd1, 32'd0);  // nothing grouped: tail is item size
            send_item(CMD_COMPUTE, 31'd0, 32'd0);
            send_reshape($urandom_range(0, 3) != 0, 6);
            wait_idle();
        end
    endtask

    task automatic test_random();
        while (items_sent < ITEMS_TOTAL) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 5) == 0) send_noise();
            else send_reshape($urandom_range(0, 3) != 0, 8);
        end
        wait_idle();
    endtask

    // receiver holds off while the sender keeps pushing
    task automatic test_backpressure();
        idle_on  = 0;
        hold_req = HOLD_LEN;
        repeat (6) send_reshape(1, 12);
        wait_idle();
    endtask

    // receiver stall: random gap per result, plus the long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  = 0;
            hold_left   = 0;
        end else begin
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (o_out_valid && !i_out_stall)
                stall_left = idle_on ? $urandom_range(0, 19) : 0;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_stride_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_strides.size() == 0) begin
                $error("unexpected result: status %0d axis %0d", o_status, o_axis_index);
                err_count++;
            end else begin
                want = pending_strides.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    err_count++;
                end
                if (o_axis_index !== want.axis_index) begin
                    $error("axis_index: expected %0d, got %0d", want.axis_index, o_axis_index);
                    err_count++;
                end
                if (o_new_stride !== want.new_stride) begin
                    $error("new_stride: expected %0h, got %0h", want.new_stride, o_new_stride);
                    err_count++;
                end
                if (o_stride_valid !== want.stride_valid) begin
                    $error("stride_valid: expected %0d, got %0d", want.stride_valid,
                           o_stride_valid);
                    err_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    err_count++;
                end
            end
        end
    end

    // watchdog: cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || i_cfg_we) begin
            wdog = 0;
        end else begin
            wdog++;
            if (wdog >= WDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_command     <= CMD_LOAD_OLD;
        i_axis_size   <= '0;
        i_axis_stride <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_FORTRAN;
        i_cfg_wdata   <= '0;
        err_count      = 0;
        items_sent     = 0;
        idle_on        = 1;
        hold_req       = 0;
        wdog           = 0;
        shd_old_n      = 0;
        shd_new_n      = 0;
        shd_ovf        = 0;
        shd_fortran    = 0;
        shd_item_bytes = ITEM_BYTES_RST;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_overflow();
        test_config();
        test_backpressure();
        test_random();

        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
